### rtl/core/hashed_timer_wheel_core_macros.svh
// ----------------------------------------------------------------------------
// Timer wheel assertion macros
// Immediate-reporting wrappers for concurrent assertions; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef HASHED_TIMER_WHEEL_CORE_MACROS_SVH
`define HASHED_TIMER_WHEEL_CORE_MACROS_SVH
`ifndef SYNTH
`define HTW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HTW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HTW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HTW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/htw_pkg.sv
// ----------------------------------------------------------------------------
// Timer wheel package
// Sizes, operation codes, item structs and sequencer states.
// ----------------------------------------------------------------------------
package htw_pkg;
  localparam int NumSlots  = 64;
  localparam int NumTimers = 32;
  localparam int SlotW     = $clog2(NumSlots);
  localparam int TidW      = 5;
  localparam int HeadW     = 6;   // handle or NIL

  typedef enum logic [1:0] {
    OP_SCHED  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_ADV    = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  localparam logic [HeadW-1:0] Nil = HeadW'(NumTimers);

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  timer_id;
    logic [5:0]  delay;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] expired_id;
    logic [5:0] expired_count;
    logic [6:0] next_timeout;
    logic       was_scheduled;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNL_RD,
    ST_UNL_WR,
    ST_APP_RD,
    ST_APP_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_QRY_RD,
    ST_QRY_CHK,
    ST_DONE,
    ST_OUT
  } state_t;
endpackage

### rtl/core/hashed_timer_wheel_core.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel core
// Slot lists over a fixed handle pool with schedule, cancel, advance, query.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// in_     | in  | in_valid/in_ready   | htw_pkg::in_item_t
// out_    | out | out_valid/out_ready | htw_pkg::out_item_t
//
// Schedule and cancel: an idle cancel goes straight to the report; an armed
// handle is unlinked (read, write) and a schedule then appends it (read,
// write). Advance scans up to 64 slots and expires up to 32 handles; a report
// waiting in the output register stalls the scan. Query looks at up to 64
// slots.
// Reset clears all heads to empty and all handles to idle at once.
// in_ready is high only in the idle state.
module hashed_timer_wheel_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  htw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output htw_pkg::out_item_t out_data
);
  localparam int SW = htw_pkg::SlotW;
  localparam int HW = htw_pkg::HeadW;
  localparam int NT = htw_pkg::NumTimers;
  localparam int TW = htw_pkg::TidW;
  localparam int WW = 2 * HW;   // slot word: {head, tail}

  // slot words live in RAM; a slot never written reads as empty
  logic [htw_pkg::NumSlots-1:0] head_vld_r;
  logic [HW-1:0]   t_next_r [NT];
  logic [HW-1:0]   t_prev_r [NT];
  logic [SW-1:0]   t_slot_r [NT];
  logic [NT-1:0]   t_act_r;
  logic [31:0]     last_time_r;

  htw_pkg::state_t state_r, state_nxt;
  htw_pkg::in_item_t item_r;
  htw_pkg::out_item_t out_r;
  logic            out_vld_r;
  logic [SW-1:0]   slot_r;     // scan pointer and RAM address
  logic [SW:0]     left_r;     // slots left to scan
  logic [5:0]      cnt_r;
  logic            ws_r;

  logic            ram_we;
  logic            ram_re;
  logic [WW-1:0]   ram_wdata;
  logic [WW-1:0]   ram_rdata;

  htw_ram #(.Width(WW), .Depth(htw_pkg::NumSlots)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (slot_r),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // slot word read back at slot_r
  logic [HW-1:0] rd_head, rd_tail;
  assign rd_head = head_vld_r[slot_r] ? ram_rdata[WW-1:HW] : htw_pkg::Nil;
  assign rd_tail = ram_rdata[HW-1:0];

  // links of the handle named by the current item
  logic [HW-1:0] self_id, self_prev, self_next;
  assign self_id   = HW'(item_r.timer_id);
  assign self_prev = t_prev_r[item_r.timer_id];
  assign self_next = t_next_r[item_r.timer_id];

  // links of the head being popped by the scan
  logic          slot_busy;
  logic [HW-1:0] pop_next, pop_prev;
  assign slot_busy = (rd_head < HW'(NT));
  assign pop_next  = t_next_r[rd_head[TW-1:0]];
  assign pop_prev  = t_prev_r[rd_head[TW-1:0]];

  assign in_ready  = (state_r == htw_pkg::ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      htw_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.op)
            htw_pkg::OP_ADV:   state_nxt = htw_pkg::ST_SCAN_RD;
            htw_pkg::OP_QUERY: state_nxt = htw_pkg::ST_QRY_RD;
            default: begin
              // the 5-bit handle always lies inside the pool
              if (t_act_r[in_data.timer_id]) state_nxt = htw_pkg::ST_UNL_RD;
              else if (in_data.op == htw_pkg::OP_SCHED) state_nxt = htw_pkg::ST_APP_RD;
              else state_nxt = htw_pkg::ST_DONE;
            end
          endcase
        end
      end
      htw_pkg::ST_UNL_RD: state_nxt = htw_pkg::ST_UNL_WR;
      htw_pkg::ST_UNL_WR: begin
        if (item_r.op == htw_pkg::OP_SCHED) state_nxt = htw_pkg::ST_APP_RD;
        else state_nxt = htw_pkg::ST_DONE;
      end
      htw_pkg::ST_APP_RD: state_nxt = htw_pkg::ST_APP_WR;
      htw_pkg::ST_APP_WR: state_nxt = htw_pkg::ST_DONE;
      htw_pkg::ST_SCAN_RD: begin
        if (left_r == '0) state_nxt = htw_pkg::ST_DONE;
        else state_nxt = htw_pkg::ST_SCAN_CHK;
      end
      htw_pkg::ST_SCAN_CHK: begin
        // hold a pop while a report still waits in the output register
        if (!slot_busy || !out_vld_r) state_nxt = htw_pkg::ST_SCAN_RD;
      end
      htw_pkg::ST_QRY_RD: begin
        if (left_r == '0) state_nxt = htw_pkg::ST_DONE;
        else state_nxt = htw_pkg::ST_QRY_CHK;
      end
      htw_pkg::ST_QRY_CHK: begin
        if (rd_head != htw_pkg::Nil) state_nxt = htw_pkg::ST_DONE;
        else state_nxt = htw_pkg::ST_QRY_RD;
      end
      htw_pkg::ST_DONE: begin
        if (!out_vld_r) state_nxt = htw_pkg::ST_OUT;
      end
      htw_pkg::ST_OUT: begin
        if (!out_vld_r) state_nxt = htw_pkg::ST_IDLE;
      end
      default: state_nxt = htw_pkg::ST_IDLE;
    endcase
  end

  // slot RAM control
  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = {rd_head, rd_tail};
    case (state_r)
      htw_pkg::ST_UNL_RD, htw_pkg::ST_APP_RD: ram_re = 1'b1;
      htw_pkg::ST_SCAN_RD, htw_pkg::ST_QRY_RD: ram_re = (left_r != '0);
      htw_pkg::ST_UNL_WR: begin
        // drop the handle from its slot ends
        ram_we    = 1'b1;
        ram_wdata = {(rd_head == self_id) ? self_next : rd_head,
                     (rd_tail == self_id) ? self_prev : rd_tail};
      end
      htw_pkg::ST_APP_WR: begin
        // append at the tail; an empty slot takes the handle as head too
        ram_we    = 1'b1;
        ram_wdata = {(rd_head == htw_pkg::Nil) ? self_id : rd_head, self_id};
      end
      htw_pkg::ST_SCAN_CHK: begin
        // pop the head: always the first of its list
        ram_we    = slot_busy && !out_vld_r;
        ram_wdata = {pop_next, (rd_tail == rd_head) ? pop_prev : rd_tail};
      end
      default: ;
    endcase
  end

  logic [31:0] dtime;
  assign dtime = in_data.now_time - last_time_r;

  // datapath and list updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htw_pkg::ST_IDLE;
      head_vld_r  <= '0;
      t_act_r     <= '0;
      last_time_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_vld_r && out_ready) out_vld_r <= 1'b0;
      if (ram_we) head_vld_r[slot_r] <= 1'b1;
      case (state_r)
        htw_pkg::ST_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            cnt_r  <= '0;
            case (in_data.op)
              htw_pkg::OP_ADV: begin
                slot_r <= last_time_r[SW-1:0];
                if (in_data.now_time < last_time_r) left_r <= '0;
                else if (dtime >= 32'(htw_pkg::NumSlots - 1))
                  left_r <= (SW+1)'(htw_pkg::NumSlots);
                else left_r <= (SW+1)'(dtime) + (SW+1)'(1);
              end
              htw_pkg::OP_QUERY: begin
                slot_r <= in_data.now_time[SW-1:0];
                left_r <= (SW+1)'(htw_pkg::NumSlots);
              end
              default: begin
                // point at the old slot to unlink, else at the new one
                ws_r <= t_act_r[in_data.timer_id];
                if (t_act_r[in_data.timer_id]) slot_r <= t_slot_r[in_data.timer_id];
                else slot_r <= last_time_r[SW-1:0] + in_data.delay;
              end
            endcase
          end
        end
        htw_pkg::ST_UNL_WR: begin
          if (rd_head != self_id && self_prev < HW'(NT))
            t_next_r[self_prev[TW-1:0]] <= self_next;
          if (rd_tail != self_id && self_next < HW'(NT))
            t_prev_r[self_next[TW-1:0]] <= self_prev;
          t_act_r[item_r.timer_id] <= 1'b0;
          slot_r <= last_time_r[SW-1:0] + item_r.delay;
        end
        htw_pkg::ST_APP_RD: begin
          t_next_r[item_r.timer_id] <= htw_pkg::Nil;
          t_slot_r[item_r.timer_id] <= slot_r;
        end
        htw_pkg::ST_APP_WR: begin
          t_act_r[item_r.timer_id] <= 1'b1;
          if (rd_head == htw_pkg::Nil) t_prev_r[item_r.timer_id] <= htw_pkg::Nil;
          else begin
            t_prev_r[item_r.timer_id] <= rd_tail;
            if (rd_tail < HW'(NT)) t_next_r[rd_tail[TW-1:0]] <= self_id;
          end
        end
        htw_pkg::ST_SCAN_CHK: begin
          if (slot_busy) begin
            if (!out_vld_r) begin
              if (rd_tail != rd_head && pop_next < HW'(NT))
                t_prev_r[pop_next[TW-1:0]] <= pop_prev;
              t_act_r[rd_head[TW-1:0]] <= 1'b0;
              out_r     <= '{kind: 1'b0, expired_id: rd_head[TW-1:0], expired_count: '0,
                             next_timeout: '0, was_scheduled: 1'b0, last: 1'b0};
              out_vld_r <= 1'b1;
              cnt_r     <= cnt_r + 6'd1;
            end
          end else begin
            slot_r <= slot_r + SW'(1);
            left_r <= left_r - (SW+1)'(1);
          end
        end
        htw_pkg::ST_QRY_CHK: begin
          if (rd_head == htw_pkg::Nil) begin
            slot_r <= slot_r + SW'(1);
            left_r <= left_r - (SW+1)'(1);
          end
        end
        htw_pkg::ST_DONE: begin
          if (!out_vld_r) begin
            out_r <= '{kind: 1'b1, expired_id: '0,
                       expired_count: (item_r.op == htw_pkg::OP_ADV) ? cnt_r : '0,
                       next_timeout: (item_r.op != htw_pkg::OP_QUERY) ? 7'd0 :
                         (left_r == (SW+1)'(htw_pkg::NumSlots)) ? 7'd1 :
                         7'(htw_pkg::NumSlots) - 7'(left_r),
                       was_scheduled: (item_r.op == htw_pkg::OP_SCHED ||
                                       item_r.op == htw_pkg::OP_CANCEL) ? ws_r : 1'b0,
                       last: 1'b1};
            out_vld_r <= 1'b1;
            if (item_r.op == htw_pkg::OP_ADV) last_time_r <= item_r.now_time;
          end
        end
        default: ;
      endcase
    end
  end

`include "hashed_timer_wheel_core_macros.svh"

  `HTW_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !out_vld_r)
  `HTW_ASSERT_NXT(a_scan_end, clk, rst_n, state_r == htw_pkg::ST_SCAN_RD && left_r == '0, state_r == htw_pkg::ST_DONE)
  `HTW_ASSERT_IMP(a_cnt_max, clk, rst_n, state_r == htw_pkg::ST_SCAN_CHK, cnt_r <= 6'(NT))
  `HTW_ASSERT_IMP(a_left_max, clk, rst_n, state_r == htw_pkg::ST_SCAN_RD, left_r <= (SW+1)'(htw_pkg::NumSlots))
  `HTW_ASSERT_NXT(a_out_hold, clk, rst_n, out_vld_r && !out_ready, out_vld_r && $stable(out_r))
endmodule

// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one registered read per cycle, at one address; read data holds
// until the next read.
// ----------------------------------------------------------------------------
module htw_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    if (re) rdata_r <= mem_r[addr];
  end
endmodule
